### hdl/clq_pkg.sv
// shared types and constants of the circular linked queue
`timescale 1ns / 1ps
package clq_pkg;

  localparam int PoolSize = 16;
  localparam int SlotW    = $clog2(PoolSize);
  localparam int CountW   = $clog2(PoolSize + 1);

  // action field of an input transaction
  localparam logic ActAppend = 1'b0;
  localparam logic ActRemove = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LINKED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_UNLINKED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_FAIL,
    OP_APPEND_FIRST,
    OP_APPEND,
    OP_REMOVE_LAST,
    OP_REMOVE
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_SPLICE,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic             action;
    logic [SlotW-1:0] element;
  } clq_in_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  head_index;
    logic [CountW-1:0] element_count;
    logic              queue_empty;
  } clq_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic link_wr;
    logic commit;
    logic splice_wr;
    logic result_ld;
  } clq_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op_new;
    op_e  op_held;
    logic out_free;
  } clq_stat_t;

endpackage

### hdl/circular_linked_queue.sv
// top level of the circular linked queue
`timescale 1ns / 1ps
// One circular doubly linked queue over a pool of 16 element slots. Each input
// transaction appends a slot at the tail or unlinks a slot from anywhere in the
// queue and returns one result transaction: status, head slot, element count and
// empty flag as they stand afterwards. One transaction is worked on at a time:
// a refused transaction goes from accept straight to the result step, an append
// to an empty queue or a remove of the last element passes through the link
// step, any other append or remove through the link and splice steps, and the
// result may wait for the output register to free up. The splice step comes
// from the link memories: the neighbor links are read first, and each memory
// has one write port, so new element and neighbor links are written in separate
// cycles. Input is taken again once the result is loaded, even if not yet taken.
module circular_linked_queue
  import clq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  clq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output clq_out_t out_data_o
);

  clq_cmd_t  cmd;
  clq_stat_t stat;

  clq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

### hdl/clq_ctrl.sv
// controller state machine of the circular linked queue
`timescale 1ns / 1ps
module clq_ctrl
  import clq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  clq_stat_t stat_i,
  output clq_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (stat_i.op_new == OP_FAIL) ? S_RESULT : S_LINK;
        end
      end
      S_LINK: begin
        if (stat_i.op_held inside {OP_APPEND, OP_REMOVE}) begin
          state_d = S_SPLICE;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SPLICE: state_d = S_RESULT;
      S_RESULT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_LINK: begin
        cmd_o.commit  = 1'b1;
        cmd_o.link_wr = stat_i.op_held inside {OP_APPEND_FIRST, OP_APPEND};
      end
      S_SPLICE: cmd_o.splice_wr = 1'b1;
      S_RESULT: cmd_o.result_ld = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### hdl/clq_dp.sv
// datapath of the circular linked queue: link memories, flags, head, count, result
`timescale 1ns / 1ps
module clq_dp
  import clq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  clq_in_t   in_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output clq_out_t  out_data_o,
  input  clq_cmd_t  cmd_i,
  output clq_stat_t stat_o
);

  logic [SlotW-1:0] next_mem [PoolSize];
  logic [SlotW-1:0] prev_mem [PoolSize];
  logic [SlotW-1:0] next_rd_q, prev_rd_q;

  logic [PoolSize-1:0] linked_q;
  logic [SlotW-1:0]    head_q;
  logic [CountW-1:0]   count_q;

  logic             action_q;
  logic [SlotW-1:0] elem_q;
  op_e              op_q, op_d;
  status_e          status_q, status_d;

  logic     out_valid_q;
  clq_out_t out_q;

  // decode of the incoming transaction against the current queue
  logic in_pool, in_linked, count_zero;
  assign in_pool    = 32'(in_data_i.element) < PoolSize;
  assign in_linked  = in_pool && linked_q[in_data_i.element];
  assign count_zero = (count_q == '0);

  always_comb begin
    op_d     = OP_FAIL;
    status_d = ST_OK;
    if (in_data_i.action == ActAppend) begin
      if (in_linked || !in_pool) begin
        status_d = ST_LINKED;
      end else begin
        op_d = count_zero ? OP_APPEND_FIRST : OP_APPEND;
      end
    end else begin
      if (count_zero) begin
        status_d = ST_EMPTY;
      end else if (!in_linked) begin
        status_d = ST_UNLINKED;
      end else begin
        op_d = (count_q == CountW'(1)) ? OP_REMOVE_LAST : OP_REMOVE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= in_data_i.action;
      elem_q   <= in_data_i.element;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_FAIL;
    end else if (cmd_i.accept) begin
      op_q <= op_d;
    end
  end

  // append reads the tail (prev of head), remove reads both links of the element
  logic [SlotW-1:0] prev_raddr;
  assign prev_raddr = (in_data_i.action == ActRemove) ? in_data_i.element : head_q;

  // one write port per link memory, shared by the link and splice steps
  logic             mem_we;
  logic [SlotW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
  logic             first;
  assign first  = (op_q == OP_APPEND_FIRST);
  assign mem_we = cmd_i.link_wr || cmd_i.splice_wr;

  always_comb begin
    if (cmd_i.link_wr) begin
      nx_waddr = elem_q;
      nx_wdata = first ? elem_q : head_q;
      pv_waddr = elem_q;
      pv_wdata = first ? elem_q : prev_rd_q;
    end else if (action_q == ActAppend) begin
      // append: tail.next and head.prev point at the new element
      nx_waddr = prev_rd_q;
      nx_wdata = elem_q;
      pv_waddr = head_q;
      pv_wdata = elem_q;
    end else begin
      // remove: neighbors point at each other
      nx_waddr = prev_rd_q;
      nx_wdata = next_rd_q;
      pv_waddr = next_rd_q;
      pv_wdata = prev_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      next_mem[nx_waddr] <= nx_wdata;
      prev_mem[pv_waddr] <= pv_wdata;
    end
    if (cmd_i.accept) begin
      next_rd_q <= next_mem[in_data_i.element];
      prev_rd_q <= prev_mem[prev_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q <= '0;
      head_q   <= '0;
      count_q  <= '0;
    end else if (cmd_i.commit) begin
      case (op_q)
        OP_APPEND_FIRST: begin
          linked_q[elem_q] <= 1'b1;
          head_q           <= elem_q;
          count_q          <= count_q + CountW'(1);
        end
        OP_APPEND: begin
          linked_q[elem_q] <= 1'b1;
          count_q          <= count_q + CountW'(1);
        end
        OP_REMOVE_LAST: begin
          linked_q[elem_q] <= 1'b0;
          head_q           <= '0;
          count_q          <= '0;
        end
        OP_REMOVE: begin
          linked_q[elem_q] <= 1'b0;
          count_q          <= count_q - CountW'(1);
          if (elem_q == head_q) begin
            head_q <= next_rd_q;
          end
        end
        default: ;
      endcase
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_ld) begin
      out_q.status        <= status_q;
      out_q.head_index    <= head_q;
      out_q.element_count <= count_q;
      out_q.queue_empty   <= count_zero;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.op_new   = op_d;
  assign stat_o.op_held  = op_q;
  assign stat_o.out_free = out_free;

endmodule
